// ===== design/i2cms_pkg.sv =====
// Package for the I2C master bit sequencer: beat payload types, command codes,
// phase encoding and the tick counter width.
// No dependencies; imported by i2cms_engine and i2c_master_bit_sequencer.
package i2cms_pkg;

    // Width of the per-phase tick counter.
    localparam int unsigned TICK_COUNT_BITS = 16;
    // Width used to compare the tick counter against the configured phase length.
    localparam int unsigned CMP_BITS = 32;

    // Command codes carried in the op field.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Number of data bits in one byte slot sequence.
    localparam logic [3:0] DATA_BITS = 4'd8;

    // Phase of the current command. Start and stop walk through PH_LOW, PH_HIGH1
    // and PH_HIGH2 as their first, second and third phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH1 = 3'd2,
        PH_HIGH2 = 3'd3,
        PH_TRAIL = 3'd4
    } phase_t;

    // One input beat: one timebase tick.
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } i2cms_in_t;

    // One result beat.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
    } i2cms_out_t;

endpackage

// ===== design/i2cms_engine.sv =====
// Phase engine of the I2C master bit sequencer: command state, tick counter,
// shifter and pin levels, advanced by one tick per enable.
// Depends on i2cms_pkg.
module i2cms_engine
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  i2cms_in_t   tick,
    input  logic [15:0] phase_ticks,
    output i2cms_out_t  result
);

    phase_t                       step_reg, step_next;
    logic [1:0]                   command_reg, command_next;
    logic [3:0]                   bit_index_reg, bit_index_next;
    logic [TICK_COUNT_BITS-1:0]   tick_count_reg, tick_count_next;
    logic [7:0]                   shifter_reg, shifter_next;
    logic                         ack_drive_reg, ack_drive_next;
    logic                         scl_level_reg, scl_level_next;
    logic                         sda_level_reg, sda_level_next;
    logic                         ack_flag_reg, ack_flag_next;
    logic [7:0]                   rx_data_reg, rx_data_next;

    logic [15:0] limit;
    logic        phase_end;
    logic        load_levels;
    logic        done;
    logic        drv_scl;
    logic        drv_sda;

    assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign phase_end = (CMP_BITS'(tick_count_reg) >= CMP_BITS'(limit))
                       || (tick_count_reg == {TICK_COUNT_BITS{1'b1}});

    // State transitions for one tick.
    always_comb
    begin
        step_next       = step_reg;
        command_next    = command_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        shifter_next    = shifter_reg;
        ack_drive_next  = ack_drive_reg;
        ack_flag_next   = ack_flag_reg;
        rx_data_next    = rx_data_reg;
        load_levels     = 1'b0;
        done            = 1'b0;
        if (advance)
        begin
            if (step_reg == PH_IDLE)
            begin
                if (tick.cmd_valid)
                begin
                    command_next    = tick.op;
                    bit_index_next  = 4'd0;
                    shifter_next    = (tick.op == OP_WRITE) ? tick.tx_byte : 8'd0;
                    if (tick.op == OP_READ)
                    begin
                        ack_drive_next = tick.ack_level;
                    end
                    step_next       = PH_LOW;
                    tick_count_next = TICK_COUNT_BITS'(1);
                    load_levels     = 1'b1;
                end
            end
            else if (phase_end)
            begin
                if ((command_reg == OP_START) || (command_reg == OP_STOP))
                begin
                    unique case (step_reg)
                        PH_LOW:   step_next = PH_HIGH1;
                        PH_HIGH1: step_next = PH_HIGH2;
                        default:  done = 1'b1;
                    endcase
                end
                else
                begin
                    unique case (step_reg)
                        PH_LOW:
                        begin
                            step_next = PH_HIGH1;
                        end
                        PH_HIGH1:
                        begin
                            // Middle of SCL high: sample the line.
                            if (bit_index_reg < DATA_BITS)
                            begin
                                if (command_reg == OP_READ)
                                begin
                                    shifter_next = {shifter_reg[6:0], tick.sda_in};
                                end
                            end
                            else if (command_reg == OP_WRITE)
                            begin
                                ack_flag_next = ~tick.sda_in;
                            end
                            step_next = PH_HIGH2;
                        end
                        PH_HIGH2:
                        begin
                            if (bit_index_reg < DATA_BITS)
                            begin
                                if (command_reg == OP_WRITE)
                                begin
                                    shifter_next = {shifter_reg[6:0], 1'b0};
                                end
                                bit_index_next = bit_index_reg + 4'd1;
                                step_next      = PH_LOW;
                            end
                            else
                            begin
                                step_next = PH_TRAIL;
                            end
                        end
                        default:
                        begin
                            if (command_reg == OP_READ)
                            begin
                                rx_data_next = shifter_reg;
                            end
                            done = 1'b1;
                        end
                    endcase
                end
                if (done)
                begin
                    step_next       = PH_IDLE;
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = TICK_COUNT_BITS'(1);
                    load_levels     = 1'b1;
                end
            end
            else
            begin
                tick_count_next = tick_count_reg + TICK_COUNT_BITS'(1);
            end
        end
    end

    // Pin levels of the phase being entered.
    always_comb
    begin
        if (command_next == OP_START)
        begin
            drv_scl = (step_next != PH_HIGH2);
            drv_sda = (step_next == PH_LOW);
        end
        else if (command_next == OP_STOP)
        begin
            drv_scl = (step_next != PH_LOW);
            drv_sda = (step_next == PH_HIGH2);
        end
        else if (step_next == PH_TRAIL)
        begin
            drv_scl = 1'b0;
            drv_sda = 1'b1;
        end
        else
        begin
            drv_scl = (step_next != PH_LOW);
            if (bit_index_next >= DATA_BITS)
            begin
                drv_sda = (command_next == OP_READ) ? ack_drive_next : 1'b1;
            end
            else
            begin
                drv_sda = (command_next == OP_WRITE) ? shifter_next[7] : 1'b1;
            end
        end
    end

    assign scl_level_next = load_levels ? drv_scl : scl_level_reg;
    assign sda_level_next = load_levels ? drv_sda : sda_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= PH_IDLE;
            command_reg    <= OP_START;
            bit_index_reg  <= 4'd0;
            tick_count_reg <= '0;
            shifter_reg    <= 8'd0;
            ack_drive_reg  <= 1'b1;
            scl_level_reg  <= 1'b1;
            sda_level_reg  <= 1'b1;
            ack_flag_reg   <= 1'b0;
            rx_data_reg    <= 8'd0;
        end
        else
        begin
            step_reg       <= step_next;
            command_reg    <= command_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            shifter_reg    <= shifter_next;
            ack_drive_reg  <= ack_drive_next;
            scl_level_reg  <= scl_level_next;
            sda_level_reg  <= sda_level_next;
            ack_flag_reg   <= ack_flag_next;
            rx_data_reg    <= rx_data_next;
        end
    end

    assign result.scl_out  = scl_level_next;
    assign result.sda_out  = sda_level_next;
    assign result.busy_res = (step_next != PH_IDLE);
    assign result.done_res = done;
    assign result.rx_byte  = rx_data_next;
    assign result.ack_ok   = ack_flag_next;

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: handshakes, phase length register
// and result register around the phase engine.
// Depends on i2cms_pkg and i2cms_engine.
//
//  Channel | Direction | Beat payload       | Handshake
//  --------+-----------+--------------------+----------------------
//  in      | input     | i2cms_in_t (tick)  | in_valid / in_ready
//  out     | output    | i2cms_out_t        | out_valid / out_ready
//  cfg     | input     | phase_ticks, 16 b  | cfg_valid / cfg_ready
//
// Every input beat is one timebase tick and yields exactly one result beat. The
// engine updates its state in the cycle the tick is accepted, and the result
// lands in the output register on the same edge, so one tick is taken every
// clock cycle unless the output stalls; the result shows in the cycle after.
// After reset the bus is released, the engine is idle and phase_ticks is 7.
// A new tick is accepted while the result register is empty or is being drained
// in the same cycle; a stalled output holds the result and stops input intake.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  i2cms_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output i2cms_out_t  out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] phase_ticks_reg;
    logic        out_valid_reg;
    i2cms_out_t  out_data_reg;
    i2cms_out_t  engine_result;
    logic        in_accept;

    // Always writable; the user must change the phase length only while idle.
    assign cfg_ready = 1'b1;

    // The result register frees up in the same cycle it is drained.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    i2cms_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_accept),
        .tick        (in_data),
        .phase_ticks (phase_ticks_reg),
        .result      (engine_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= 16'd7;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                phase_ticks_reg <= cfg_data;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= engine_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
